/* rtl/core/bhp_pkg.sv */
// Shared types and constants of the binary header prelude parser.
// Used by the channel interfaces, the parse core and the top level; no dependencies.
package bhp_pkg;

  localparam int unsigned DefMaxFileTags  = 16384;
  localparam int unsigned DefPositionBits = 40;

  localparam int unsigned RefW     = 24;
  localparam int unsigned TagW     = 15;
  localparam int unsigned OffW     = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [RefW-1:0] RefLimitReset = 24'd10_000_000;
  localparam logic [TagW-1:0] TagLimitReset = 15'd16_384;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRefLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTagLimit = 2'd1;

  // Result status codes.
  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StNeedMore = 4'd1;
  localparam logic [3:0] StRefLimit = 4'd2;
  localparam logic [3:0] StTagLimit = 4'd3;
  localparam logic [3:0] StBadTag   = 4'd4;
  localparam logic [3:0] StBadLen   = 4'd5;
  localparam logic [3:0] StBadElem  = 4'd6;
  localparam logic [3:0] StArrOvf   = 4'd7;
  localparam logic [3:0] StPosOvf   = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic [RefW-1:0] ref_limit;
    logic [TagW-1:0] tag_limit;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [3:0]      status;
    logic [OffW-1:0] cnt_field_pos;
    logic [63:0]     chunk_count;
    logic [OffW-1:0] header_end;
  } res_t;

endpackage

/* rtl/core/bhp_if.sv */
// Valid/ready channel interfaces of the binary header prelude parser.
// Depends on bhp_pkg for field widths.
interface bhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface bhp_out_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               status;
  logic [bhp_pkg::OffW-1:0] cnt_field_pos;
  logic [63:0]              chunk_count;
  logic [bhp_pkg::OffW-1:0] header_end;
  modport source (output valid, status, cnt_field_pos, chunk_count, header_end,
                  input ready);
  modport sink (input valid, status, cnt_field_pos, chunk_count, header_end,
                output ready);
endinterface

interface bhp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bhp_pkg::CfgIdxW-1:0]  index;
  logic [bhp_pkg::CfgDataW-1:0] value;
  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface

/* rtl/core/bhp_core.sv */
// Parse state machine of the binary header prelude parser, one byte per step,
// with the file-tag type table. Depends on bhp_pkg.
module bhp_core #(
  parameter int unsigned MaxFileTags  = bhp_pkg::DefMaxFileTags,
  parameter int unsigned PositionBits = bhp_pkg::DefPositionBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  bhp_pkg::byte_t byte_i,
  input  bhp_pkg::cfg_t  cfg_i,
  output bhp_pkg::res_t  res_o
);

  localparam int unsigned AddrW = (MaxFileTags > 1) ? $clog2(MaxFileTags) : 1;
  localparam int unsigned TagW  = bhp_pkg::TagW;
  localparam int unsigned RefW  = bhp_pkg::RefW;
  localparam int unsigned OffW  = bhp_pkg::OffW;
  localparam logic [PositionBits-1:0] PosMax = '1;

  localparam logic [4:0] PhFlag      = 5'd0;
  localparam logic [4:0] PhRefCnt    = 5'd1;
  localparam logic [4:0] PhRNameLen  = 5'd2;
  localparam logic [4:0] PhRNameSkip = 5'd3;
  localparam logic [4:0] PhChunks    = 5'd4;
  localparam logic [4:0] PhTagCnt    = 5'd5;
  localparam logic [4:0] PhDNameLen  = 5'd6;
  localparam logic [4:0] PhDNameSkip = 5'd7;
  localparam logic [4:0] PhDKind     = 5'd8;
  localparam logic [4:0] PhDLen      = 5'd9;
  localparam logic [4:0] PhDElem     = 5'd10;
  localparam logic [4:0] PhVFixed    = 5'd11;
  localparam logic [4:0] PhVStrLen   = 5'd12;
  localparam logic [4:0] PhVStrSkip  = 5'd13;
  localparam logic [4:0] PhVArrLen   = 5'd14;
  localparam logic [4:0] PhVArrSkip  = 5'd15;
  localparam logic [4:0] PhVEStrLen  = 5'd16;
  localparam logic [4:0] PhVEStrSkip = 5'd17;

  localparam logic [3:0] KindArray  = 4'd7;
  localparam logic [3:0] KindString = 4'd8;

  function automatic logic [3:0] atomic_bytes(input logic [3:0] k);
    logic [3:0] r;
    unique case (k)
      4'd0, 4'd1: r = 4'd1;
      4'd2:       r = 4'd2;
      4'd3, 4'd5: r = 4'd4;
      4'd4, 4'd6: r = 4'd8;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] atomic_shift(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd2:       r = 2'd1;
      4'd3, 4'd5: r = 2'd2;
      4'd4, 4'd6: r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] length_bytes(input logic [7:0] k);
    logic [3:0] r;
    unique case (k)
      8'd1:    r = 4'd1;
      8'd2:    r = 4'd2;
      8'd3:    r = 4'd4;
      8'd4:    r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_skip(input logic [4:0] ph);
    return (ph == PhRNameSkip) || (ph == PhDNameSkip) || (ph == PhVFixed) ||
           (ph == PhVStrSkip) || (ph == PhVArrSkip) || (ph == PhVEStrSkip);
  endfunction

  logic [4:0]              phase_q, phase_d;
  logic [3:0]              fcnt_q, fcnt_d;
  logic [63:0]             fasm_q, fasm_d;
  logic [63:0]             skip_q, skip_d;
  logic [RefW-1:0]         refs_q, refs_d;
  logic [TagW-1:0]         tags_q, tags_d;
  logic [1:0]              sect_q, sect_d;
  logic [TagW-1:0]         ftc_q, ftc_d;
  logic [10:0]             ctt_q, ctt_d;
  logic [63:0]             strs_q, strs_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [PositionBits-1:0] choff_q, choff_d;
  logic [63:0]             chcnt_q, chcnt_d;
  logic                    drain_q, drain_d;
  logic                    vstart_q, vstart_d;

  logic [10:0]      tbl_mem [MaxFileTags];
  logic [10:0]      rd_q;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [10:0]      wr_data;
  logic [16:0]      widx, ridx;

  logic        act, fin, restart;
  logic [3:0]  st;
  logic [7:0]  b;
  logic [63:0] v;
  logic [3:0]  fw;
  logic [10:0] t;
  logic [3:0]  elem;
  logic        f_fc, f_desc, f_nextref, f_nextdesc, f_nextarr, f_valdone, f_nextval;

  always_comb begin
    phase_d  = phase_q;
    fcnt_d   = fcnt_q;
    fasm_d   = fasm_q;
    skip_d   = skip_q;
    refs_d   = refs_q;
    tags_d   = tags_q;
    sect_d   = sect_q;
    ftc_d    = ftc_q;
    ctt_d    = ctt_q;
    strs_d   = strs_q;
    pos_d    = pos_q;
    choff_d  = choff_q;
    chcnt_d  = chcnt_q;
    drain_d  = drain_q;
    vstart_d = vstart_q;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    widx     = 17'(ftc_q) - 17'(tags_q);
    act      = 1'b0;
    fin      = 1'b0;
    restart  = 1'b0;
    st       = bhp_pkg::StOk;
    b        = byte_i.data_byte;
    v        = '0;
    fw       = 4'd2;
    t        = '0;
    elem     = ctt_q[10:7];
    f_fc       = 1'b0;
    f_desc     = 1'b0;
    f_nextref  = 1'b0;
    f_nextdesc = 1'b0;
    f_nextarr  = 1'b0;
    f_valdone  = 1'b0;
    f_nextval  = 1'b0;
    res_o      = '0;

    if (step_i) begin
      if (drain_q) begin
        restart = byte_i.last_byte;
      end else if (pos_q == PosMax) begin
        fin = 1'b1;
        st  = bhp_pkg::StPosOvf;
      end else begin
        act   = 1'b1;
        pos_d = pos_q + 1'b1;

        // Consume the byte in the current phase.
        unique case (phase_q)
          PhFlag: begin
            phase_d = PhRefCnt;
            fcnt_d  = '0;
            fasm_d  = '0;
          end
          PhDKind: begin
            if (b == 8'd7) begin
              phase_d = PhDLen;
            end else if (b > 8'd8) begin
              fin = 1'b1;
              st  = bhp_pkg::StBadTag;
            end else begin
              f_desc = 1'b1;
              t      = {7'd0, b[3:0]};
            end
          end
          PhDLen: begin
            fasm_d  = {56'd0, b};
            phase_d = PhDElem;
          end
          PhDElem: begin
            // The length type is only judged once the element byte is in.
            if (length_bytes(fasm_q[7:0]) == 4'd0) begin
              fin = 1'b1;
              st  = bhp_pkg::StBadLen;
            end else if (b > 8'd8 || b == 8'd7) begin
              fin = 1'b1;
              st  = bhp_pkg::StBadElem;
            end else begin
              f_desc = 1'b1;
              t      = {b[3:0], fasm_q[2:0], KindArray};
            end
          end
          PhRNameSkip, PhDNameSkip, PhVFixed, PhVStrSkip, PhVArrSkip, PhVEStrSkip: begin
            if (skip_q != '0) skip_d = skip_q - 1'b1;
          end
          PhRefCnt, PhChunks, PhRNameLen, PhTagCnt, PhDNameLen, PhVStrLen, PhVArrLen,
          PhVEStrLen: begin
            if (phase_q == PhRefCnt || phase_q == PhChunks) begin
              fw = 4'd8;
            end else if (phase_q == PhVArrLen) begin
              fw = length_bytes({5'd0, ctt_q[6:4]});
            end
            fasm_d = fasm_q;
            fasm_d[{fcnt_q[2:0], 3'b000} +: 8] = b;
            fcnt_d = fcnt_q + 1'b1;
            f_fc   = (fcnt_d >= fw);
            v      = fasm_d;
          end
          default: ;
        endcase

        // A completed little-endian field.
        if (f_fc) begin
          unique case (phase_q)
            PhRefCnt: begin
              if (v > {40'd0, cfg_i.ref_limit}) begin
                fin = 1'b1;
                st  = bhp_pkg::StRefLimit;
              end else begin
                refs_d    = v[RefW-1:0];
                f_nextref = 1'b1;
              end
            end
            PhRNameLen: begin
              phase_d = PhRNameSkip;
              skip_d  = v;
            end
            PhChunks: begin
              chcnt_d = v;
              sect_d  = '0;
              phase_d = PhTagCnt;
              fcnt_d  = '0;
              fasm_d  = '0;
            end
            PhTagCnt: begin
              if (v > {49'd0, cfg_i.tag_limit} ||
                  (sect_q == 2'd0 && v > 64'(MaxFileTags))) begin
                fin = 1'b1;
                st  = bhp_pkg::StTagLimit;
              end else begin
                if (sect_q == 2'd0) ftc_d = v[TagW-1:0];
                tags_d     = v[TagW-1:0];
                f_nextdesc = 1'b1;
              end
            end
            PhDNameLen: begin
              phase_d = PhDNameSkip;
              skip_d  = v;
            end
            PhVStrLen: begin
              phase_d = PhVStrSkip;
              skip_d  = v;
            end
            PhVEStrLen: begin
              phase_d = PhVEStrSkip;
              skip_d  = v;
            end
            default: begin
              if (elem == KindString) begin
                strs_d    = v;
                f_nextarr = 1'b1;
              end else if (atomic_bytes(elem) == 4'd0) begin
                fin = 1'b1;
                st  = bhp_pkg::StBadElem;
              end else if ((atomic_shift(elem) == 2'd1 && v[63]) ||
                           (atomic_shift(elem) == 2'd2 && v[63:62] != 2'd0) ||
                           (atomic_shift(elem) == 2'd3 && v[63:61] != 3'd0)) begin
                fin = 1'b1;
                st  = bhp_pkg::StArrOvf;
              end else begin
                phase_d = PhVArrSkip;
                skip_d  = v << atomic_shift(elem);
              end
            end
          endcase
        end

        // A finished tag description; first-section types go to the table.
        if (f_desc) begin
          if (sect_q == 2'd0 && tags_q != '0) begin
            wr_en   = 1'b1;
            wr_addr = widx[AddrW-1:0];
            wr_data = t;
          end
          if (tags_q != '0) tags_d = tags_q - 1'b1;
          f_nextdesc = 1'b1;
        end

        // A skip that has run out, including one of zero length.
        if (!fin && is_skip(phase_d) && skip_d == '0) begin
          unique case (phase_d)
            PhRNameSkip: begin
              if (refs_d != '0) refs_d = refs_d - 1'b1;
              f_nextref = 1'b1;
            end
            PhDNameSkip: phase_d = PhDKind;
            PhVEStrSkip: begin
              if (strs_d != '0) strs_d = strs_d - 1'b1;
              f_nextarr = 1'b1;
            end
            default: f_valdone = 1'b1;
          endcase
        end

        if (f_nextref) begin
          fcnt_d = '0;
          fasm_d = '0;
          if (refs_d == '0) begin
            choff_d = pos_d;
            phase_d = PhChunks;
          end else begin
            phase_d = PhRNameLen;
          end
        end

        if (f_nextdesc) begin
          fcnt_d = '0;
          fasm_d = '0;
          if (tags_d == '0) begin
            sect_d = sect_d + 1'b1;
            if (sect_d != 2'd3) begin
              phase_d = PhTagCnt;
            end else begin
              tags_d    = ftc_d;
              vstart_d  = 1'b1;
              f_nextval = 1'b1;
            end
          end else begin
            phase_d = PhDNameLen;
          end
        end

        if (f_nextarr) begin
          if (strs_d == '0) begin
            f_valdone = 1'b1;
          end else begin
            phase_d = PhVEStrLen;
            fcnt_d  = '0;
            fasm_d  = '0;
          end
        end

        if (f_valdone) begin
          if (tags_d != '0) tags_d = tags_d - 1'b1;
          f_nextval = 1'b1;
        end

        // The next file-tag value; its type was fetched from the table ahead of time.
        if (f_nextval) begin
          if (tags_d == '0) begin
            fin = 1'b1;
            st  = bhp_pkg::StOk;
          end else begin
            ctt_d  = rd_q;
            fcnt_d = '0;
            fasm_d = '0;
            if (rd_q[3:0] == KindString) begin
              phase_d = PhVStrLen;
            end else if (rd_q[3:0] == KindArray) begin
              phase_d = PhVArrLen;
            end else begin
              phase_d = PhVFixed;
              skip_d  = {60'd0, atomic_bytes(rd_q[3:0])};
            end
          end
        end
      end

      if (fin) begin
        res_o.valid  = 1'b1;
        res_o.status = st;
        if (st == bhp_pkg::StOk) begin
          res_o.cnt_field_pos = OffW'(choff_d);
          res_o.chunk_count   = chcnt_d;
          res_o.header_end    = OffW'(pos_d);
        end
        if (byte_i.last_byte) restart = 1'b1;
        else drain_d = 1'b1;
      end else if (act && byte_i.last_byte) begin
        res_o.valid  = 1'b1;
        res_o.status = bhp_pkg::StNeedMore;
        restart      = 1'b1;
      end
    end

    if (restart) begin
      phase_d  = PhFlag;
      fcnt_d   = '0;
      fasm_d   = '0;
      skip_d   = '0;
      refs_d   = '0;
      tags_d   = '0;
      sect_d   = '0;
      ftc_d    = '0;
      ctt_d    = '0;
      strs_d   = '0;
      pos_d    = '0;
      choff_d  = '0;
      chcnt_d  = '0;
      drain_d  = 1'b0;
      vstart_d = 1'b0;
    end

    // Address of the type that the next value will need.
    ridx    = 17'(ftc_d) - 17'(tags_d) + 17'd1;
    rd_addr = vstart_d ? ridx[AddrW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    rd_q <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFlag;
      fcnt_q   <= '0;
      fasm_q   <= '0;
      skip_q   <= '0;
      refs_q   <= '0;
      tags_q   <= '0;
      sect_q   <= '0;
      ftc_q    <= '0;
      ctt_q    <= '0;
      strs_q   <= '0;
      pos_q    <= '0;
      choff_q  <= '0;
      chcnt_q  <= '0;
      drain_q  <= 1'b0;
      vstart_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fcnt_q   <= fcnt_d;
      fasm_q   <= fasm_d;
      skip_q   <= skip_d;
      refs_q   <= refs_d;
      tags_q   <= tags_d;
      sect_q   <= sect_d;
      ftc_q    <= ftc_d;
      ctt_q    <= ctt_d;
      strs_q   <= strs_d;
      pos_q    <= pos_d;
      choff_q  <= choff_d;
      chcnt_q  <= chcnt_d;
      drain_q  <= drain_d;
      vstart_q <= vstart_d;
    end
  end

endmodule

/* rtl/core/binary_header_prelude_parser.sv */
// Top level of the binary header prelude parser: configuration registers,
// output register with skid stage, and the parse core. Depends on bhp_pkg, bhp_if, bhp_core.

// The parser takes one header byte per clock cycle while ready is high and registers a
// result word, into the output register or, if that is still full, the skid stage, for the
// byte that finishes the header, raises an error or carries last_byte. Ready drops only while
// the skid stage holds a second result that the sink has not yet taken. File-tag types are
// kept in a MaxFileTags x 11 bit table with a registered read port, which is addressed one
// value ahead for back-to-back values. After a result the parser drops bytes until last_byte.
module binary_header_prelude_parser #(
  parameter int unsigned MaxFileTags  = bhp_pkg::DefMaxFileTags,
  parameter int unsigned PositionBits = bhp_pkg::DefPositionBits
) (
  input logic       clk_i,
  input logic       rst_ni,
  bhp_in_if.sink    byte_i,
  bhp_out_if.source result_o,
  bhp_cfg_if.sink   cfg_i
);

  bhp_pkg::cfg_t  cfg_q;
  bhp_pkg::byte_t in_word;
  bhp_pkg::res_t  res;
  bhp_pkg::res_t  out_q, skid_q;
  logic           step;
  logic           pop;

  assign byte_i.ready = !skid_q.valid;
  assign step         = byte_i.valid && byte_i.ready;
  assign in_word      = '{data_byte: byte_i.data_byte, last_byte: byte_i.last_byte};
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_limit <= bhp_pkg::RefLimitReset;
      cfg_q.tag_limit <= bhp_pkg::TagLimitReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == bhp_pkg::CfgRefLimit) begin
        cfg_q.ref_limit <= cfg_i.value[bhp_pkg::RefW-1:0];
      end else if (cfg_i.index == bhp_pkg::CfgTagLimit) begin
        cfg_q.tag_limit <= cfg_i.value[bhp_pkg::TagW-1:0];
      end
    end
  end

  bhp_core #(
    .MaxFileTags  (MaxFileTags),
    .PositionBits (PositionBits)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_word),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign pop = out_q.valid && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else begin
      if (skid_q.valid) begin
        if (pop) begin
          out_q        <= skid_q;
          skid_q.valid <= 1'b0;
        end
      end else if (res.valid) begin
        if (!out_q.valid || pop) out_q <= res;
        else skid_q <= res;
      end else if (pop) begin
        out_q.valid <= 1'b0;
      end
    end
  end

  assign result_o.valid         = out_q.valid;
  assign result_o.status        = out_q.status;
  assign result_o.cnt_field_pos = out_q.cnt_field_pos;
  assign result_o.chunk_count   = out_q.chunk_count;
  assign result_o.header_end    = out_q.header_end;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q.valid |-> out_q.valid)
    else $error("skid stage holds a result while the output register is empty");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.status <= bhp_pkg::StPosOvf)
    else $error("result status outside the defined codes");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.status != bhp_pkg::StOk) |->
      (result_o.chunk_count == '0 && result_o.cnt_field_pos == '0 &&
       result_o.header_end == '0))
    else $error("error result carries non-zero value fields");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q.valid && !pop) |=> skid_q.valid)
    else $error("stalled result left the skid stage");

endmodule

/* tb/tb_binary_header_prelude_parser.sv */
// Self-checking testbench of the binary header prelude parser: directed words, random well-formed
// and broken headers, with an in-bench predictor of results. Depends on bhp_pkg, bhp_if and the top level.
module tb_binary_header_prelude_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth   = int'(bhp_pkg::DefMaxFileTags);
  localparam int Running      = -1;
  localparam int IdleLimit    = 20000;
  localparam int TargetBytes  = 1450;
  localparam longint unsigned PosMax = (64'd1 << 40) - 1;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    P_FLAG, P_REFCNT, P_RNAMELEN, P_RNAMESKIP, P_CHUNKS, P_TAGCNT,
    P_DNAMELEN, P_DNAMESKIP, P_DKIND, P_DLEN, P_DELEM,
    P_VFIXED, P_VSTRLEN, P_VSTRSKIP, P_VARRLEN, P_VARRSKIP,
    P_VESTRLEN, P_VESTRSKIP
  } phase_e;

  // Field kinds of a tag description.
  localparam int KindArray  = 7;
  localparam int KindString = 8;

  typedef struct packed {
    logic [3:0]  status;
    logic [39:0] chunks_off;
    logic [63:0] chunks;
    logic [39:0] payload_off;
  } header_result_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [3:0] status;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  bhp_in_if  in_if ();
  bhp_out_if out_if ();
  bhp_cfg_if cfg_if ();

  binary_header_prelude_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (in_if),
    .result_o (out_if),
    .cfg_i    (cfg_if)
  );

  // Predictor state.
  logic [23:0]  ref_limit_q;
  logic [14:0]  tag_limit_q;
  phase_e       phase_q;
  int           fbytes_q;
  logic [63:0]  fasm_q;
  logic [63:0]  skip_q;
  int           refs_left_q;
  int           tags_left_q;
  int           section_q;
  int           file_tags_q;
  logic [10:0]  type_table [TableDepth];
  logic [10:0]  cur_type_q;
  logic [63:0]  strings_left_q;
  logic [39:0]  pos_q;
  logic [39:0]  chunks_off_q;
  logic [63:0]  chunks_q;
  logic         draining_q;

  header_result_t expected_results [$];
  int errors = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int headers_sent = 0;
  int idle_cycles = 0;
  bit sink_stalls = 1'b1;
  bit src_gaps = 1'b1;
  logic [7:0] header_bytes [$];
  int status_hits [9];

  function automatic int atomic_width(int k);
    case (k)
      0, 1: return 1;
      2: return 2;
      3, 5: return 4;
      4, 6: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic int length_width(int k);
    case (k)
      1: return 1;
      2: return 2;
      3: return 4;
      4: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic void restart_parse();
    phase_q = P_FLAG;
    fbytes_q = 0;
    fasm_q = '0;
    skip_q = '0;
    refs_left_q = 0;
    tags_left_q = 0;
    section_q = 0;
    file_tags_q = 0;
    cur_type_q = '0;
    strings_left_q = '0;
    pos_q = '0;
    chunks_off_q = '0;
    chunks_q = '0;
    draining_q = 1'b0;
  endfunction

  function automatic void start_field(phase_e ph);
    phase_q = ph;
    fbytes_q = 0;
    fasm_q = '0;
  endfunction

  function automatic void start_skip(phase_e ph, logic [63:0] n);
    phase_q = ph;
    skip_q = n;
  endfunction

  function automatic bit is_skip(phase_e ph);
    return ph inside {P_RNAMESKIP, P_DNAMESKIP, P_VFIXED, P_VSTRSKIP, P_VARRSKIP, P_VESTRSKIP};
  endfunction

  function automatic int next_reference();
    if (refs_left_q == 0) begin
      chunks_off_q = pos_q;
      start_field(P_CHUNKS);
    end else begin
      start_field(P_RNAMELEN);
    end
    return Running;
  endfunction

  function automatic int next_value();
    int idx;
    int kind;
    if (tags_left_q == 0) return int'(bhp_pkg::StOk);
    idx = file_tags_q - tags_left_q;
    if (idx >= TableDepth) idx = 0;
    cur_type_q = type_table[idx];
    kind = int'(cur_type_q[3:0]);
    if (kind == KindString) start_field(P_VSTRLEN);
    else if (kind == KindArray) start_field(P_VARRLEN);
    else start_skip(P_VFIXED, 64'(atomic_width(kind)));
    return Running;
  endfunction

  function automatic int value_done();
    if (tags_left_q > 0) tags_left_q--;
    return next_value();
  endfunction

  function automatic int next_array_string();
    if (strings_left_q == 0) return value_done();
    start_field(P_VESTRLEN);
    return Running;
  endfunction

  function automatic int next_description();
    if (tags_left_q == 0) begin
      section_q++;
      if (section_q < 3) begin
        start_field(P_TAGCNT);
        return Running;
      end
      tags_left_q = file_tags_q;
      return next_value();
    end
    start_field(P_DNAMELEN);
    return Running;
  endfunction

  function automatic int description_done(logic [10:0] t);
    int idx;
    if (section_q == 0 && tags_left_q > 0) begin
      idx = file_tags_q - tags_left_q;
      if (idx < TableDepth) type_table[idx] = t;
    end
    if (tags_left_q > 0) tags_left_q--;
    return next_description();
  endfunction

  function automatic int skip_finished();
    case (phase_q)
      P_RNAMESKIP: begin
        if (refs_left_q > 0) refs_left_q--;
        return next_reference();
      end
      P_DNAMESKIP: begin
        phase_q = P_DKIND;
        return Running;
      end
      P_VESTRSKIP: begin
        if (strings_left_q > 0) strings_left_q--;
        return next_array_string();
      end
      default: return value_done();
    endcase
  endfunction

  function automatic int field_complete(logic [63:0] v);
    int elem;
    int w;
    case (phase_q)
      P_REFCNT: begin
        if (v > 64'(ref_limit_q)) return int'(bhp_pkg::StRefLimit);
        refs_left_q = int'(v);
        return next_reference();
      end
      P_RNAMELEN: begin
        start_skip(P_RNAMESKIP, v);
        return Running;
      end
      P_CHUNKS: begin
        chunks_q = v;
        section_q = 0;
        start_field(P_TAGCNT);
        return Running;
      end
      P_TAGCNT: begin
        if (v > 64'(tag_limit_q)) return int'(bhp_pkg::StTagLimit);
        if (section_q == 0) begin
          if (v > 64'(TableDepth)) return int'(bhp_pkg::StTagLimit);
          file_tags_q = int'(v);
        end
        tags_left_q = int'(v);
        return next_description();
      end
      P_DNAMELEN: begin
        start_skip(P_DNAMESKIP, v);
        return Running;
      end
      P_VSTRLEN: begin
        start_skip(P_VSTRSKIP, v);
        return Running;
      end
      P_VESTRLEN: begin
        start_skip(P_VESTRSKIP, v);
        return Running;
      end
      default: begin
        elem = int'(cur_type_q[10:7]);
        if (elem == KindString) begin
          strings_left_q = v;
          return next_array_string();
        end
        w = atomic_width(elem);
        if (w == 0) return int'(bhp_pkg::StBadElem);
        if (v > AllOnes / 64'(w)) return int'(bhp_pkg::StArrOvf);
        start_skip(P_VARRSKIP, v * 64'(w));
        return Running;
      end
    endcase
  endfunction

  function automatic int consume(logic [7:0] b);
    int w;
    case (phase_q)
      P_FLAG: begin
        start_field(P_REFCNT);
        return Running;
      end
      P_DKIND: begin
        if (b == KindArray) begin
          phase_q = P_DLEN;
          return Running;
        end
        if (b > KindString) return int'(bhp_pkg::StBadTag);
        return description_done(11'(b));
      end
      P_DLEN: begin
        fasm_q = 64'(b);
        phase_q = P_DELEM;
        return Running;
      end
      P_DELEM: begin
        if (length_width(int'(fasm_q)) == 0) return int'(bhp_pkg::StBadLen);
        if (b > KindString || b == KindArray) return int'(bhp_pkg::StBadElem);
        return description_done({b[3:0], fasm_q[2:0], 4'(KindArray)});
      end
      default: ;
    endcase
    if (is_skip(phase_q)) begin
      if (skip_q > 0) skip_q--;
      return Running;
    end
    case (phase_q)
      P_REFCNT, P_CHUNKS: w = 8;
      P_VARRLEN: w = length_width(int'(cur_type_q[6:4]));
      default: w = 2;
    endcase
    if (fbytes_q < 8) fasm_q |= 64'(b) << (8 * fbytes_q);
    fbytes_q++;
    if (fbytes_q < w) return Running;
    return field_complete(fasm_q);
  endfunction

  // Advances the predictor by one accepted word; returns 1 when a result is due.
  function automatic bit predict_header_byte(logic [7:0] b, logic last,
                                             output header_result_t r);
    int st;
    r = '0;
    if (draining_q) begin
      if (last) restart_parse();
      return 1'b0;
    end
    if (64'(pos_q) >= PosMax) begin
      st = int'(bhp_pkg::StPosOvf);
    end else begin
      pos_q++;
      st = consume(b);
      while (st == Running && is_skip(phase_q) && skip_q == 0) st = skip_finished();
    end
    if (st == Running) begin
      if (!last) return 1'b0;
      st = int'(bhp_pkg::StNeedMore);
    end
    r.status = 4'(st);
    if (st == int'(bhp_pkg::StOk)) begin
      r.chunks_off = chunks_off_q;
      r.chunks = chunks_q;
      r.payload_off = pos_q;
    end
    if (last) restart_parse();
    else draining_q = 1'b1;
    return 1'b1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: random stalls, and every taken word compared with the oldest expectation.
  initial begin
    int stall_left;
    header_result_t want;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, status %0d", $realtime, out_if.status);
        end else begin
          want = expected_results.pop_front();
          if (out_if.status !== want.status || out_if.cnt_field_pos !== want.chunks_off ||
              out_if.chunk_count !== want.chunks || out_if.header_end !== want.payload_off) begin
            errors++;
            $display("%0t: mismatch, expected status %0d off %0h chunks %0h payload %0h",
                     $realtime, want.status, want.chunks_off, want.chunks, want.payload_off);
            $display("%0t:           actual status %0d off %0h chunks %0h payload %0h",
                     $realtime, out_if.status, out_if.cnt_field_pos, out_if.chunk_count,
                     out_if.header_end);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles", $realtime, IdleLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic last, bit typed = 1'b0,
                           logic [3:0] typed_status = '0);
    header_result_t r;
    int gap;
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    if (predict_header_byte(b, last, r)) begin
      if (typed) begin
        r = '0;
        r.status = typed_status;
      end
      if (r.status <= bhp_pkg::StPosOvf) status_hits[r.status]++;
      expected_results = {expected_results, r};
    end
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 2);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(logic [bhp_pkg::CfgIdxW-1:0] idx,
                                logic [bhp_pkg::CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.value <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == bhp_pkg::CfgRefLimit) ref_limit_q = val[23:0];
    else if (idx == bhp_pkg::CfgTagLimit) tag_limit_q = val[14:0];
  endtask

  function automatic void put_byte(logic [7:0] x);
    header_bytes = {header_bytes, x};
  endfunction

  function automatic void push_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_random(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom));
  endfunction

  function automatic void push_name();
    int n;
    n = $urandom_range(0, 4);
    push_le(64'(n), 2);
    push_random(n);
  endfunction

  // Builds one header, mostly well formed; returns early once it has been broken.
  function automatic void build_header();
    logic [63:0] v;
    logic [10:0] types [$];
    int cnt;
    int k;
    int lt;
    int el;
    header_bytes.delete();
    push_random(1);
    case ($urandom_range(0, 19))
      0: v = {$urandom, $urandom};
      1: v = 64'(ref_limit_q) + 64'($urandom_range(0, 1));
      default: v = 64'($urandom_range(0, 3));
    endcase
    push_le(v, 8);
    if (v > 3) begin
      push_random($urandom_range(0, 3));
      return;
    end
    for (int i = 0; i < int'(v); i++) push_name();
    push_le({$urandom, $urandom}, 8);
    for (int s = 0; s < 3; s++) begin
      if ($urandom_range(0, 24) == 0) begin
        cnt = (s == 0 && $urandom_range(0, 1) == 0) ? TableDepth + 1 : int'(tag_limit_q) + 1;
        push_le(64'(cnt), 2);
        push_random($urandom_range(0, 3));
        return;
      end
      cnt = $urandom_range(0, 4);
      if (cnt > int'(tag_limit_q)) cnt = int'(tag_limit_q);
      push_le(64'(cnt), 2);
      for (int d = 0; d < cnt; d++) begin
        push_name();
        if ($urandom_range(0, 29) == 0) begin
          // Broken description: unknown kind, length kind or element kind.
          case ($urandom_range(0, 2))
            0: put_byte(8'($urandom_range(9, 255)));
            1: begin
              put_byte(8'(KindArray));
              put_byte($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(5, 255)));
              put_byte(8'($urandom));
            end
            default: begin
              put_byte(8'(KindArray));
              put_byte(8'($urandom_range(1, 4)));
              put_byte($urandom_range(0, 1) ? 8'(KindArray) : 8'($urandom_range(9, 255)));
            end
          endcase
          push_random($urandom_range(0, 3));
          return;
        end
        k = $urandom_range(0, 8);
        if (k == KindArray) begin
          lt = $urandom_range(1, 4);
          el = $urandom_range(0, 7);
          if (el == KindArray) el = KindString;
          put_byte(8'(KindArray));
          put_byte(8'(lt));
          put_byte(8'(el));
          if (s == 0) types = {types, {4'(el), 3'(lt), 4'(KindArray)}};
        end else begin
          put_byte(8'(k));
          if (s == 0) types = {types, 11'(k)};
        end
      end
    end
    foreach (types[i]) begin
      k = int'(types[i][3:0]);
      if (k == KindString) begin
        push_name();
      end else if (k == KindArray) begin
        lt = length_width(int'(types[i][6:4]));
        el = int'(types[i][10:7]);
        if (lt == 8 && atomic_width(el) > 1 && $urandom_range(0, 3) == 0) begin
          push_le(AllOnes - 64'($urandom_range(0, 3)), 8);
          push_random($urandom_range(0, 3));
          return;
        end
        cnt = $urandom_range(0, 3);
        push_le(64'(cnt), lt);
        for (int e = 0; e < cnt; e++) begin
          if (el == KindString) push_name();
          else push_random(atomic_width(el));
        end
      end else begin
        push_random(atomic_width(k));
      end
    end
    push_random($urandom_range(0, 3));
  endfunction

  task automatic run_headers(int target);
    int len;
    while (bytes_sent < target) begin
      build_header();
      len = header_bytes.size();
      // Now and then the stream stops short of the end of the header.
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
      src_gaps = ($urandom_range(0, 4) != 0);
      sink_stalls = ($urandom_range(0, 4) != 0);
      if (headers_sent == 20) wait_drained();
      for (int i = 0; i < len; i++) send_word(header_bytes[i], i == len - 1);
      headers_sent++;
    end
  endtask

  initial begin
    directed_row_t rows [$];
    int step;
    rows = '{
      '{8'hA5, 1'b1, 1'b1, bhp_pkg::StNeedMore},
      '{8'h00, 1'b0, 1'b0, bhp_pkg::StOk},
      '{8'hFF, 1'b0, 1'b0, bhp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, bhp_pkg::StOk},
      '{8'hFF, 1'b0, 1'b0, bhp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, bhp_pkg::StOk},
      '{8'hFF, 1'b0, 1'b0, bhp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, bhp_pkg::StOk},
      '{8'hFF, 1'b0, 1'b0, bhp_pkg::StOk}, '{8'hFF, 1'b0, 1'b1, bhp_pkg::StRefLimit},
      '{8'h3C, 1'b0, 1'b0, bhp_pkg::StOk},
      '{8'h00, 1'b1, 1'b0, bhp_pkg::StOk},
      '{8'h5A, 1'b0, 1'b0, bhp_pkg::StOk}, '{8'h00, 1'b0, 1'b0, bhp_pkg::StOk},
      '{8'h00, 1'b1, 1'b1, bhp_pkg::StNeedMore}
    };
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= bhp_pkg::CfgRefLimit;
    cfg_if.value <= '0;
    ref_limit_q = bhp_pkg::RefLimitReset;
    tag_limit_q = bhp_pkg::TagLimitReset;
    restart_parse();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].data, rows[i].last, rows[i].typed, rows[i].status);
    run_headers(300);
    wait_drained();

    // Extremes of both limits, then a tight setting.
    step = TargetBytes / 4;
    write_register(bhp_pkg::CfgRefLimit, 24'd0);
    write_register(bhp_pkg::CfgTagLimit, 24'd0);
    run_headers(300 + step);
    wait_drained();
    write_register(bhp_pkg::CfgRefLimit, 24'hFF_FFFF);
    write_register(bhp_pkg::CfgTagLimit, 24'd16384);
    run_headers(300 + 2 * step);
    wait_drained();
    write_register(bhp_pkg::CfgRefLimit, 24'd2);
    write_register(bhp_pkg::CfgTagLimit, 24'd2);
    run_headers(TargetBytes);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d bytes in %0d headers, %0d results; ok %0d, need-more %0d,",
             bytes_sent, headers_sent, results_seen, status_hits[bhp_pkg::StOk],
             status_hits[bhp_pkg::StNeedMore]);
    $display("limit errors %0d/%0d, type errors %0d/%0d/%0d, array overflow %0d.",
             status_hits[bhp_pkg::StRefLimit], status_hits[bhp_pkg::StTagLimit],
             status_hits[bhp_pkg::StBadTag], status_hits[bhp_pkg::StBadLen],
             status_hits[bhp_pkg::StBadElem], status_hits[bhp_pkg::StArrOvf]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/bhp_pkg.sv
rtl/core/bhp_if.sv
rtl/core/bhp_core.sv
rtl/core/binary_header_prelude_parser.sv
tb/tb_binary_header_prelude_parser.sv
